[design/dds_pkg.sv]
// Shared constants, register codes and sine table builder for the DDS sine source.
`default_nettype none

package dds_pkg;

  // Default sizes of the table index and of one sample
  localparam int DEF_TABLE_INDEX_BITS = 10;
  localparam int DEF_SAMPLE_BITS      = 12;

  // Datapath widths that the register map fixes
  localparam int PHASE_BITS     = 32;
  localparam int AMP_BITS       = 11;
  localparam int AMP_SHIFT      = 11;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int IN_DATA_BITS   = 8;

  // Register reset values
  localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET   = 32'h0000_0000;
  localparam logic [AMP_BITS-1:0]   AMPLITUDE_RESET    = 11'h7FF;
  localparam logic [PHASE_BITS-1:0] PHASE_OFFSET_RESET = 32'hAAAA_AAAA;

  // Register indexes on the configuration port
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_AMPLITUDE    = 2'd1,
    REG_PHASE_OFFSET = 2'd2
  } cfg_reg_t;

  // pi/2 in Q62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  // Rounded (a * b) / 2^62 with a full 128-bit product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + (128'd1 << 61);
    return prod[125:62];
  endfunction

  // Unsigned 64-bit quotient by shift and subtract, used only while building the table
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    int          b;
    quo = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sin(pi/2 * j / 2^qbits) in Q62 by its Taylor series
  function automatic logic [63:0] sin_quarter(input logic [63:0] j, input int qbits);
    logic [63:0] mask;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] div;
    int          k;
    mask = (64'd1 << qbits) - 64'd1;
    x    = (HALF_PI_Q62 >> qbits) * j + (((HALF_PI_Q62 & mask) * j) >> qbits);
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (k = 1; k < 40; k++) begin
      if (term != 64'd0) begin
        div  = 64'(2 * k) * 64'(2 * k + 1);
        term = div_u64(mul_q62(term, x2), div);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  // Table entry round(C + (C-1)*sin(2*pi*idx/N)), built by quarter-wave symmetry
  function automatic logic [15:0] sine_entry(input int idx, input int index_bits,
                                             input int sample_bits);
    int          qbits;
    logic [63:0] quarter;
    logic [63:0] quad;
    logic [63:0] j;
    logic [63:0] pos;
    logic [63:0] center;
    logic [63:0] mag;
    logic [63:0] val;
    qbits   = index_bits - 2;
    quarter = 64'd1 << qbits;
    quad    = 64'(idx) >> qbits;
    j       = 64'(idx) & (quarter - 64'd1);
    pos     = quad[0] ? (quarter - j) : j;
    center  = 64'd1 << (sample_bits - 1);
    mag     = mul_q62(sin_quarter(pos, qbits), center - 64'd1);
    if (quad[1]) begin
      val = center - {32'd0, mag[31:0]};
    end else begin
      val = center + {32'd0, mag[31:0]};
    end
    return val[15:0];
  endfunction

endpackage

`default_nettype wire

[design/dds_sine_rom.sv]
// Sine lookup ROM with a registered read port.
`default_nettype none

module dds_sine_rom import dds_pkg::*; #(
  parameter int IDX_BITS  = DEF_TABLE_INDEX_BITS,
  parameter int DATA_BITS = DEF_SAMPLE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [IDX_BITS-1:0]  rd_addr,
  output logic      [DATA_BITS-1:0] rd_data
);

  localparam int DEPTH = 1 << IDX_BITS;

  logic [DATA_BITS-1:0] rom [DEPTH];

  // Fill each entry from the table builder at elaboration
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_entry
    localparam logic [15:0] ENTRY = sine_entry(gi, IDX_BITS, DATA_BITS);
    assign rom[gi] = ENTRY[DATA_BITS-1:0];
  end

  // Read one entry per cycle while rd_en is high; the registered data appears the cycle after
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= rom[rd_addr];
    end
  end

endmodule

`default_nettype wire

[design/dds_sine_phase_offset_generator.sv]
// DDS sine source top level: phase accumulator, offset, sine ROM and amplitude scaling.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-----------------------------------
//   s_*      | in        | s_tvalid / s_tready        | s_tdata[0] sync_pending
//   m_*      | out       | m_tvalid / m_tready        | m_tdata[SAMPLE_BITS-1:0] sample
//   cfg_*    | in        | cfg_wr_en (no wait)        | cfg_index, cfg_data
//
// One word enters per cycle while m_tready stays high; its sample passes the stages in order.
// Stages: accumulator update, ROM read (registered memory port), multiply, shift/recenter.
// Each stage holds its word while the stage after it is full and cannot advance, so bubbles close under stall.
// rst (synchronous) clears the accumulator, the stage valid bits and the registers to
// their defaults; the ROM is constant and needs no clearing pass.
`default_nettype none

module dds_sine_phase_offset_generator import dds_pkg::*; #(
  parameter  int TABLE_INDEX_BITS = DEF_TABLE_INDEX_BITS,
  parameter  int SAMPLE_BITS      = DEF_SAMPLE_BITS,
  localparam int OUT_W            = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [IN_DATA_BITS-1:0]   s_tdata,    // [0] sync_pending, rest zero
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic      [OUT_W-1:0]          m_tdata,    // [SAMPLE_BITS-1:0] sample, rest zero
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PROD_W = SAMPLE_BITS + AMP_BITS + 2;
  localparam logic [SAMPLE_BITS:0]   CENTER_X = (SAMPLE_BITS + 1)'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] CENTER   = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  // Configuration registers
  logic [PHASE_BITS-1:0] phase_step;
  logic [AMP_BITS-1:0]   amplitude;
  logic [PHASE_BITS-1:0] phase_offset;

  // Pipeline state
  logic                       v1, v2, v3, vo;
  logic                       rdy1, rdy2, rdy3, rdy_o;
  logic [PHASE_BITS-1:0]      phase_acc;
  logic [PHASE_BITS-1:0]      phase_acc_next;
  logic [PHASE_BITS-1:0]      phase;
  logic [SAMPLE_BITS-1:0]     rom_q;
  logic signed [SAMPLE_BITS:0] centered;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   shifted;
  logic [SAMPLE_BITS-1:0]     sample;
  logic                       accept;

  // Write configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step   <= PHASE_STEP_RESET;
      amplitude    <= AMPLITUDE_RESET;
      phase_offset <= PHASE_OFFSET_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PHASE_STEP:   phase_step   <= cfg_data;
        REG_AMPLITUDE:    amplitude    <= cfg_data[AMP_BITS-1:0];
        REG_PHASE_OFFSET: phase_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage advances when the next one is empty or advancing
  assign rdy_o    = !vo || m_tready;
  assign rdy3     = !v3 || rdy_o;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;
  assign accept   = s_tvalid && rdy1;

  // Clear on sync, then step the accumulator
  assign phase_acc_next = (s_tdata[0] ? '0 : phase_acc) + phase_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      vo        <= 1'b0;
    end else begin
      if (accept) begin
        phase_acc <= phase_acc_next;
      end
      if (rdy1)  v1 <= s_tvalid;
      if (rdy2)  v2 <= v1;
      if (rdy3)  v3 <= v2;
      if (rdy_o) vo <= v3;
    end
  end

  // Offset the held phase and look up the table
  assign phase = phase_acc + phase_offset;

  dds_sine_rom #(
    .IDX_BITS  (TABLE_INDEX_BITS),
    .DATA_BITS (SAMPLE_BITS)
  ) u_rom (
    .clk     (clk),
    .rd_en   (v1 && rdy2),
    .rd_addr (phase[PHASE_BITS-1 -: TABLE_INDEX_BITS]),
    .rd_data (rom_q)
  );

  // Scale the centered table value by the amplitude
  assign centered = $signed({1'b0, rom_q}) - $signed(CENTER_X);

  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      prod <= PROD_W'(centered) * $signed(PROD_W'({1'b0, amplitude}));
    end
  end

  // Floor shift and recenter into the output register
  assign shifted = prod >>> AMP_SHIFT;

  always_ff @(posedge clk) begin
    if (v3 && rdy_o) begin
      sample <= shifted[SAMPLE_BITS-1:0] + CENTER;
    end
  end

  assign m_tvalid = vo;
  assign m_tdata  = OUT_W'(sample);

endmodule

`default_nettype wire

[design/dds_stream_checker.sv]
// Port-level checks for the DDS sine source, bound to its top level.
`default_nettype none

module dds_stream_checker #(
  parameter int OUT_W = 16
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // Drop all words in flight on reset
  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output word valid right after reset");

  // Take input whenever the output side is free or draining
  a_ready_free : assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output side can move");

  // Hold a stalled output word
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output word changed or dropped");

endmodule

bind dds_sine_phase_offset_generator dds_stream_checker #(
  .OUT_W (OUT_W)
) u_stream_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

[bench/dds_sine_phase_offset_generator_test.sv]
// Self-checking bench for the DDS sine source: ticks in, predicted samples checked out.
`timescale 1ns / 100ps

module dds_sine_phase_offset_generator_test import dds_pkg::*;;

  // Sizes of the instance under test (package defaults)
  localparam int LUT_BITS  = DEF_TABLE_INDEX_BITS;
  localparam int QTR_BITS  = LUT_BITS - 2;
  localparam int LUT_SIZE  = 1 << LUT_BITS;
  localparam int SAMPLE_W  = DEF_SAMPLE_BITS;
  localparam int CENTER    = 1 << (SAMPLE_W - 1);
  localparam int OUT_W     = ((SAMPLE_W + 7) / 8) * 8;

  // pi/2 in Q62 for the table builder
  localparam logic [63:0] QTR_WAVE_Q62 = 64'h6487_ED51_10B4_611A;

  // Register index with no register behind it
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;

  // Receiver back-pressure modes
  typedef enum int {
    RX_OPEN,
    RX_BUSY_LIGHT,
    RX_BUSY_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_DATA_BITS-1:0]   s_tdata;    // [0] sync_pending, rest zero
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_W-1:0]          m_tdata;    // [SAMPLE_W-1:0] sample, rest zero
  logic                      cfg_wr_en;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  // Predictor state and register copies
  logic [SAMPLE_W-1:0]   sine_lut [LUT_SIZE];
  logic [PHASE_BITS-1:0] tone_acc;
  logic [PHASE_BITS-1:0] tone_step;
  logic [AMP_BITS-1:0]   tone_amp;
  logic [PHASE_BITS-1:0] tone_offset;

  logic [SAMPLE_W-1:0] expected_samples [$];
  logic [SAMPLE_W-1:0] want_sample;
  int                  error_count = 0;
  int                  burst_left = 0;
  int                  stall_cycles = 0;

  dds_sine_phase_offset_generator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Rounded a*b / 2^62, keeping 64 bits of the quotient
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b} + (128'd1 << 61);
    return wide[125:62];
  endfunction

  // sin(pi/2 * j / quarter) in Q62 by Taylor series
  function automatic logic [63:0] quarter_sine(input int j);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    int          k;
    x = (QTR_WAVE_Q62 >> QTR_BITS) * 64'(j)
        + (((QTR_WAVE_Q62 & ((64'd1 << QTR_BITS) - 64'd1)) * 64'(j)) >> QTR_BITS);
    x2   = q62_mul(x, x);
    term = x;
    sum  = x;
    for (k = 1; k < 40 && term != 64'd0; k++) begin
      term = q62_mul(term, x2) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // Table entry by quarter-wave symmetry
  function automatic logic [SAMPLE_W-1:0] sine_point(input int i);
    int          quad;
    int          j;
    int          pos;
    logic [63:0] mag;
    quad = i >> QTR_BITS;
    j    = i & ((1 << QTR_BITS) - 1);
    pos  = (quad & 1) ? ((1 << QTR_BITS) - j) : j;
    mag  = q62_mul(quarter_sine(pos), 64'(CENTER - 1));
    if (quad & 2) begin
      return SAMPLE_W'(32'(CENTER) - mag[31:0]);
    end else begin
      return SAMPLE_W'(32'(CENTER) + mag[31:0]);
    end
  endfunction

  // Advance the phase for one tick and return the scaled sample
  function automatic logic [SAMPLE_W-1:0] next_sample(input logic sync);
    logic [PHASE_BITS-1:0] phase;
    int                    centered;
    int                    scaled;
    if (sync) begin
      tone_acc = '0;
    end
    tone_acc = tone_acc + tone_step;
    phase    = tone_acc + tone_offset;
    centered = int'(sine_lut[phase[PHASE_BITS-1 -: LUT_BITS]]) - CENTER;
    scaled   = (centered * int'(tone_amp)) >>> AMP_SHIFT;
    return SAMPLE_W'(scaled + CENTER);
  endfunction

  // Send one tick word; bursts with random gaps between them
  task automatic send_tick(input logic sync);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_BITS-1){1'b0}}, sync};
    do @(posedge clk); while (!s_tready);
    expected_samples.push_back(next_sample(sync));
    burst_left--;
  endtask

  // Drop valid and wait until every sample has come out
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  // Drain the pipeline, write one register and mirror it in the predictor
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PHASE_STEP:   tone_step   = value;
      REG_AMPLITUDE:    tone_amp    = value[AMP_BITS-1:0];
      REG_PHASE_OFFSET: tone_offset = value;
      default: ;
    endcase
  endtask

  // Reset values: step 0, full amplitude, 240 degree offset
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Table extremes and the amplitude corner values
  task automatic test_table_points();
    wait_idle();
    write_reg(REG_PHASE_OFFSET, 32'd0);
    send_tick(1'b1);
    write_reg(REG_PHASE_OFFSET, 32'(256) << 22);
    send_tick(1'b0);
    write_reg(REG_PHASE_OFFSET, 32'(512) << 22);
    send_tick(1'b0);
    write_reg(REG_PHASE_OFFSET, 32'(768) << 22);
    send_tick(1'b0);
    write_reg(REG_PHASE_OFFSET, 32'hFFFF_FFFF);
    send_tick(1'b0);
    // amplitude 1 on a small negative value floors to -1
    write_reg(REG_AMPLITUDE, 32'd1);
    send_tick(1'b0);
    write_reg(REG_PHASE_OFFSET, 32'(768) << 22);
    send_tick(1'b0);
    write_reg(REG_PHASE_OFFSET, 32'(256) << 22);
    send_tick(1'b0);
    write_reg(REG_AMPLITUDE, 32'd0);
    send_tick(1'b0);
  endtask

  // Ignored index, masked amplitude, accumulator and offset wrap, sync clear
  task automatic test_register_edges();
    wait_idle();
    write_reg(REG_SPARE, $urandom);
    send_tick(1'b0);
    write_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
    send_tick(1'b0);
    write_reg(REG_AMPLITUDE, 32'h0000_0800);
    send_tick(1'b0);
    write_reg(REG_AMPLITUDE, 32'h0000_07FF);
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    write_reg(REG_PHASE_OFFSET, 32'd0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    write_reg(REG_PHASE_OFFSET, 32'hFFFF_FFFF);
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // Pick new register values, extremes among them
  task automatic retune();
    case ($urandom_range(0, 5))
      0:       write_reg(REG_PHASE_STEP, 32'd0);
      1:       write_reg(REG_PHASE_STEP, 32'd1);
      2:       write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
      3:       write_reg(REG_PHASE_STEP, 32'h8000_0000);
      4:       write_reg(REG_PHASE_STEP, $urandom_range(0, 32'h00FF_FFFF));
      default: write_reg(REG_PHASE_STEP, $urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       write_reg(REG_AMPLITUDE, 32'd0);
      1:       write_reg(REG_AMPLITUDE, 32'd2047);
      2:       write_reg(REG_AMPLITUDE, 32'd1);
      default: write_reg(REG_AMPLITUDE, $urandom);
    endcase
    case ($urandom_range(0, 3))
      0:       write_reg(REG_PHASE_OFFSET, 32'd0);
      1:       write_reg(REG_PHASE_OFFSET, 32'hFFFF_FFFF);
      default: write_reg(REG_PHASE_OFFSET, $urandom);
    endcase
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_SPARE, $urandom);
    end
  endtask

  // Random settings, each followed by a run of ticks with random sync density
  task automatic test_random_ticks();
    int rate;
    for (int phase_no = 0; phase_no < 10; phase_no++) begin
      wait_idle();
      retune();
      case ($urandom_range(0, 2))
        0:       rate = 64;
        1:       rate = 8;
        default: rate = 2;
      endcase
      repeat (100) send_tick($urandom_range(0, rate - 1) == 0);
    end
  endtask

  // Receiver back-pressure pattern
  initial begin
    rx_mode_t mode;
    int       span;
    int       period;
    int       count;
    m_tready = 1'b0;
    count    = 0;
    forever begin
      mode   = rx_mode_t'($urandom_range(0, 3));
      span   = $urandom_range(32, 256);
      period = $urandom_range(2, 6);
      repeat (span) begin
        @(negedge clk);
        count++;
        case (mode)
          RX_OPEN:       m_tready <= 1'b1;
          RX_BUSY_LIGHT: m_tready <= ($urandom_range(0, 9) < 7);
          RX_BUSY_HEAVY: m_tready <= ($urandom_range(0, 9) < 3);
          default:       m_tready <= (count % period == 0);
        endcase
      end
    end
  end

  // Check each output word against the oldest expected sample
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        $error("sample: unexpected word, actual %0d", m_tdata[SAMPLE_W-1:0]);
        error_count++;
      end else begin
        want_sample = expected_samples.pop_front();
        if (m_tdata[SAMPLE_W-1:0] !== want_sample) begin
          $error("sample: expected %0d, actual %0d", want_sample, m_tdata[SAMPLE_W-1:0]);
          error_count++;
        end
        if (m_tdata[OUT_W-1:SAMPLE_W] !== '0) begin
          $error("tdata pad: expected 0, actual %0h", m_tdata[OUT_W-1:SAMPLE_W]);
          error_count++;
        end
      end
    end
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    for (int i = 0; i < LUT_SIZE; i++) begin
      sine_lut[i] = sine_point(i);
    end
    tone_acc    = '0;
    tone_step   = PHASE_STEP_RESET;
    tone_amp    = AMPLITUDE_RESET;
    tone_offset = PHASE_OFFSET_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_table_points();
    test_register_edges();
    test_random_ticks();

    // Drain, then give stray words time to show up
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[dds_sine_phase_offset_generator.f]
design/dds_pkg.sv
design/dds_sine_rom.sv
design/dds_sine_phase_offset_generator.sv
design/dds_stream_checker.sv
bench/dds_sine_phase_offset_generator_test.sv
